/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication check, disabled while reset is asserted
`define ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/ucmf_pkg.sv */
// package with sequencer states, command codes and register indexes
package ucmf_pkg;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_SOLVE = 2'd1,
        MODE_FETCH = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_SOURCE     = 2'd1,
        CFG_SINK       = 2'd2,
        CFG_NONE       = 2'd3
    } cfg_index_t;

    typedef enum logic [5:0] {
        ST_CLR,
        ST_IDLE,
        ST_ADD0,
        ST_ADD1,
        ST_ADD2,
        ST_ADD3,
        ST_SINIT,
        ST_SCHK,
        ST_BCLR,
        ST_BINIT,
        ST_BPOP,
        ST_BX,
        ST_BXL,
        ST_BE,
        ST_BY,
        ST_BYL,
        ST_BT,
        ST_CCP,
        ST_DTOP,
        ST_DC,
        ST_DE,
        ST_DEL,
        ST_DP1,
        ST_DP2,
        ST_DP3,
        ST_DP4,
        ST_DAUG,
        ST_DAUG1,
        ST_DAUG2,
        ST_SFIN,
        ST_G0,
        ST_G1,
        ST_G2,
        ST_G3
    } state_t;

    localparam int NODE_W = 10;
    localparam int FLOW_W = 11;

endpackage

/* hw/rtl/ucmf_ram.sv */
// generic single write port ram with registered read
module ucmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/unit_capacity_max_flow_paths_unit.sv */
// unit-capacity max flow (dinic) with edge-disjoint path read-out
// add edge writes the forward and reverse slots and links them into both node lists, fetch scans
// the slots of the current node for the next path node, solve restores capacities then alternates level and path search
// throughput: one word at a time, busy holds off start; results are registered together with done
// most steps are a read of one of the slot or node rams, so ram read latency paces the walk
// reset: a sweep over all MAX_NODES entries writes the node list heads and tails to null, busy meanwhile
`include "assert_macros.svh"

module unit_capacity_max_flow_paths_unit #(
    parameter int MAX_NODES = 512,
    parameter int MAX_EDGES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [9:0]  from_node,
    input  logic [9:0]  to_node,
    // result side, one cycle strobe
    output logic        done,
    output logic [10:0] flow_count,
    output logic [9:0]  path_node,
    output logic        path_end,
    output logic        all_done,
    // register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    // widths that follow from the store sizes
    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = $clog2(2 * MAX_EDGES);
    localparam int SW  = $clog2(2 * MAX_EDGES + 1);
    localparam int UAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LW  = $clog2(MAX_NODES + 2);
    localparam int PW  = $clog2(MAX_NODES + 1);
    localparam int FW  = $clog2(MAX_EDGES + 1);
    localparam int CNW = $clog2(MAX_EDGES + 1);
    localparam int CW  = ($clog2(MAX_NODES + 1) > 10) ? $clog2(MAX_NODES + 1) : 10;
    localparam int IWA = $clog2(2 * MAX_EDGES + 1);
    localparam int IWB = $clog2(MAX_NODES + 1);
    localparam int IW  = (IWA > IWB) ? IWA : IWB;
    localparam logic [SW-1:0] NO_SLOT = SW'(2 * MAX_EDGES);

    ucmf_pkg::state_t state_reg, state_next;

    // configuration
    logic [9:0] node_count_reg, node_count_next;
    logic [9:0] source_reg, source_next;
    logic [9:0] sink_reg, sink_next;

    // latched command word
    logic [1:0] mode_reg, mode_next;
    logic [9:0] from_reg, from_next;
    logic [9:0] to_reg, to_next;

    // sequencer datapath
    logic [IW-1:0]  ctr_reg, ctr_next;
    logic [CNW-1:0] edges_reg, edges_next;
    logic [NW-1:0]  x_reg, x_next;
    logic [NW-1:0]  y_reg, y_next;
    logic [SW-1:0]  e_reg, e_next;
    logic [SW-1:0]  nx_reg, nx_next;
    logic           capb_reg, capb_next;
    logic [LW-1:0]  lvlx_reg, lvlx_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic [PW-1:0]  sp_reg, sp_next;
    logic [FW-1:0]  flow_reg, flow_next;
    logic [FW-1:0]  left_reg, left_next;
    logic [NW-1:0]  walk_reg, walk_next;

    // result registers
    logic        done_reg, done_next;
    logic [10:0] fc_reg, fc_next;
    logic [9:0]  pn_reg, pn_next;
    logic        pe_reg, pe_next;
    logic        ad_reg, ad_next;

    // ram ports
    logic          tgt_we, cap_we, nxt_we, fst_we, lst_we, lvl_we, cur_we, que_we, stk_we;
    logic          used_we;
    logic [AW-1:0] tgt_wa, tgt_ra, cap_wa, cap_ra, nxt_wa, nxt_ra;
    logic [NW-1:0] fst_wa, fst_ra, lst_wa, lst_ra, lvl_wa, lvl_ra, cur_wa, cur_ra;
    logic [NW-1:0] que_wa, que_ra, stk_wa, stk_ra;
    logic [UAW-1:0] used_wa, used_ra;
    logic [NW-1:0] tgt_wd, tgt_rd, que_wd, que_rd;
    logic          cap_wd, cap_rd, used_wd, used_rd;
    logic [SW-1:0] nxt_wd, nxt_rd, fst_wd, fst_rd, lst_wd, lst_rd, cur_wd, cur_rd;
    logic [AW-1:0] stk_wd, stk_rd;
    logic [LW-1:0] lvl_wd, lvl_rd;

    // decoded conditions
    logic [CW-1:0] nuse;
    logic          accept, add_ok, terms_ok, at_t, advance, at_sink;
    logic [NW-1:0] s_idx, t_idx, u_idx, v_idx, src_walk;
    logic [AW-1:0] f_slot, r_slot;
    logic [CW-1:0] xp1;

    function automatic logic node_ok(input logic [9:0] v, input logic [CW-1:0] nu);
        return (v != 10'd0) && (CW'(v) <= nu);
    endfunction

    assign nuse = (CW'(node_count_reg) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                          : CW'(node_count_reg);
    assign accept   = start && (state_reg == ucmf_pkg::ST_IDLE);
    assign s_idx    = NW'(source_reg - 10'd1);
    assign t_idx    = NW'(sink_reg - 10'd1);
    assign u_idx    = NW'(from_reg - 10'd1);
    assign v_idx    = NW'(to_reg - 10'd1);
    assign src_walk = node_ok(source_reg, nuse) ? s_idx : '0;
    assign terms_ok = node_ok(source_reg, nuse) && node_ok(sink_reg, nuse)
                      && (source_reg != sink_reg);
    // from and to are registered on accept, so the check reads the ports
    assign add_ok   = (edges_reg < CNW'(MAX_EDGES)) && node_ok(from_node, nuse)
                      && node_ok(to_node, nuse);
    assign f_slot   = AW'({edges_reg, 1'b0});
    assign r_slot   = f_slot | AW'(1);
    assign at_t     = (x_reg == t_idx);
    // level test on the slot under the cursor
    assign advance  = capb_reg && (sp_reg < PW'(MAX_NODES)) && (lvl_rd == lvlx_reg + LW'(1));
    assign xp1      = CW'(walk_reg) + CW'(1);
    assign at_sink  = (xp1 == CW'(sink_reg));

    // register write channel is always open; index 3 writes nothing
    assign cfg_ready = 1'b1;

    always_comb
    begin
        node_count_next = node_count_reg;
        source_next     = source_reg;
        sink_next       = sink_reg;
        if (cfg_valid)
        begin
            case (ucmf_pkg::cfg_index_t'(cfg_index))
                ucmf_pkg::CFG_NODE_COUNT: node_count_next = cfg_data;
                ucmf_pkg::CFG_SOURCE:     source_next     = cfg_data;
                ucmf_pkg::CFG_SINK:       sink_next       = cfg_data;
                default:                  node_count_next = node_count_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ucmf_pkg::ST_CLR:
                if (ctr_reg == IW'(MAX_NODES - 1)) state_next = ucmf_pkg::ST_IDLE;
            ucmf_pkg::ST_IDLE:
                if (start)
                begin
                    case (ucmf_pkg::mode_t'(mode))
                        ucmf_pkg::MODE_ADD:
                            state_next = add_ok ? ucmf_pkg::ST_ADD0 : ucmf_pkg::ST_IDLE;
                        ucmf_pkg::MODE_SOLVE: state_next = ucmf_pkg::ST_SINIT;
                        ucmf_pkg::MODE_FETCH: state_next = ucmf_pkg::ST_G0;
                        default:              state_next = ucmf_pkg::ST_IDLE;
                    endcase
                end
            ucmf_pkg::ST_ADD0: state_next = ucmf_pkg::ST_ADD1;
            ucmf_pkg::ST_ADD1: state_next = ucmf_pkg::ST_ADD2;
            ucmf_pkg::ST_ADD2: state_next = ucmf_pkg::ST_ADD3;
            ucmf_pkg::ST_ADD3: state_next = ucmf_pkg::ST_IDLE;
            ucmf_pkg::ST_SINIT:
                if (ctr_reg == IW'(2 * MAX_EDGES - 1)) state_next = ucmf_pkg::ST_SCHK;
            ucmf_pkg::ST_SCHK:
                state_next = terms_ok ? ucmf_pkg::ST_BCLR : ucmf_pkg::ST_SFIN;
            ucmf_pkg::ST_BCLR:
                if (ctr_reg == IW'(MAX_NODES - 1)) state_next = ucmf_pkg::ST_BINIT;
            ucmf_pkg::ST_BINIT: state_next = ucmf_pkg::ST_BPOP;
            ucmf_pkg::ST_BPOP:
                state_next = (head_reg == tail_reg) ? ucmf_pkg::ST_BT : ucmf_pkg::ST_BX;
            ucmf_pkg::ST_BX:  state_next = ucmf_pkg::ST_BXL;
            ucmf_pkg::ST_BXL: state_next = ucmf_pkg::ST_BE;
            ucmf_pkg::ST_BE:
                state_next = (e_reg == NO_SLOT) ? ucmf_pkg::ST_BPOP : ucmf_pkg::ST_BY;
            ucmf_pkg::ST_BY:  state_next = ucmf_pkg::ST_BYL;
            ucmf_pkg::ST_BYL: state_next = ucmf_pkg::ST_BE;
            ucmf_pkg::ST_BT:
                state_next = (lvl_rd == '0) ? ucmf_pkg::ST_SFIN : ucmf_pkg::ST_CCP;
            ucmf_pkg::ST_CCP:
                if (ctr_reg == IW'(MAX_NODES)) state_next = ucmf_pkg::ST_DTOP;
            ucmf_pkg::ST_DTOP:
                state_next = at_t ? ucmf_pkg::ST_DAUG : ucmf_pkg::ST_DC;
            ucmf_pkg::ST_DC:
                if (cur_rd != NO_SLOT)     state_next = ucmf_pkg::ST_DE;
                else if (sp_reg == '0)     state_next = ucmf_pkg::ST_BCLR;
                else                       state_next = ucmf_pkg::ST_DP1;
            ucmf_pkg::ST_DE:    state_next = ucmf_pkg::ST_DEL;
            ucmf_pkg::ST_DEL:   state_next = ucmf_pkg::ST_DTOP;
            ucmf_pkg::ST_DP1:   state_next = ucmf_pkg::ST_DP2;
            ucmf_pkg::ST_DP2:   state_next = ucmf_pkg::ST_DP3;
            ucmf_pkg::ST_DP3:   state_next = ucmf_pkg::ST_DP4;
            ucmf_pkg::ST_DP4:   state_next = ucmf_pkg::ST_DTOP;
            ucmf_pkg::ST_DAUG:
                state_next = (sp_reg == '0) ? ucmf_pkg::ST_DTOP : ucmf_pkg::ST_DAUG1;
            ucmf_pkg::ST_DAUG1: state_next = ucmf_pkg::ST_DAUG2;
            ucmf_pkg::ST_DAUG2: state_next = ucmf_pkg::ST_DAUG;
            ucmf_pkg::ST_SFIN:  state_next = ucmf_pkg::ST_IDLE;
            ucmf_pkg::ST_G0:
                state_next = ((left_reg == '0) || at_sink) ? ucmf_pkg::ST_IDLE
                                                            : ucmf_pkg::ST_G1;
            ucmf_pkg::ST_G1: state_next = ucmf_pkg::ST_G2;
            ucmf_pkg::ST_G2:
                state_next = (e_reg == NO_SLOT) ? ucmf_pkg::ST_IDLE : ucmf_pkg::ST_G3;
            ucmf_pkg::ST_G3:
                if (!e_reg[0] && !used_rd && !cap_rd) state_next = ucmf_pkg::ST_IDLE;
                else                                   state_next = ucmf_pkg::ST_G2;
            default: state_next = ucmf_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        mode_next = mode_reg;  from_next = from_reg;  to_next = to_reg;
        ctr_next = ctr_reg;    edges_next = edges_reg;
        x_next = x_reg;        y_next = y_reg;        e_next = e_reg;
        nx_next = nx_reg;      capb_next = capb_reg;  lvlx_next = lvlx_reg;
        head_next = head_reg;  tail_next = tail_reg;  sp_next = sp_reg;
        flow_next = flow_reg;  left_next = left_reg;  walk_next = walk_reg;
        done_next = 1'b0;      fc_next = fc_reg;      pn_next = pn_reg;
        pe_next = pe_reg;      ad_next = ad_reg;

        tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_ra = '0;
        cap_we = 1'b0; cap_wa = '0; cap_wd = 1'b0; cap_ra = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;
        fst_we = 1'b0; fst_wa = '0; fst_wd = '0; fst_ra = '0;
        lst_we = 1'b0; lst_wa = '0; lst_wd = '0; lst_ra = '0;
        lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0; lvl_ra = '0;
        cur_we = 1'b0; cur_wa = '0; cur_wd = '0; cur_ra = '0;
        que_we = 1'b0; que_wa = '0; que_wd = '0; que_ra = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
        used_we = 1'b0; used_wa = '0; used_wd = 1'b0; used_ra = '0;

        case (state_reg)
            ucmf_pkg::ST_CLR:
            begin
                fst_we = 1'b1; fst_wa = NW'(ctr_reg); fst_wd = NO_SLOT;
                lst_we = 1'b1; lst_wa = NW'(ctr_reg); lst_wd = NO_SLOT;
                ctr_next = ctr_reg + IW'(1);
            end
            ucmf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    from_next = from_node;
                    to_next   = to_node;
                    ctr_next  = '0;
                    flow_next = '0;
                end
            end
            ucmf_pkg::ST_ADD0:
            begin
                tgt_we = 1'b1; tgt_wa = f_slot; tgt_wd = v_idx;
                cap_we = 1'b1; cap_wa = f_slot; cap_wd = 1'b1;
                nxt_we = 1'b1; nxt_wa = f_slot; nxt_wd = NO_SLOT;
                fst_ra = u_idx; lst_ra = u_idx;
            end
            ucmf_pkg::ST_ADD1:
            begin
                if (fst_rd == NO_SLOT)
                begin
                    fst_we = 1'b1; fst_wa = u_idx; fst_wd = SW'(f_slot);
                end
                else
                begin
                    nxt_we = 1'b1; nxt_wa = AW'(lst_rd); nxt_wd = SW'(f_slot);
                end
                lst_we = 1'b1; lst_wa = u_idx; lst_wd = SW'(f_slot);
                tgt_we = 1'b1; tgt_wa = r_slot; tgt_wd = u_idx;
                cap_we = 1'b1; cap_wa = r_slot; cap_wd = 1'b0;
            end
            ucmf_pkg::ST_ADD2:
            begin
                nxt_we = 1'b1; nxt_wa = r_slot; nxt_wd = NO_SLOT;
                fst_ra = v_idx; lst_ra = v_idx;
            end
            ucmf_pkg::ST_ADD3:
            begin
                if (fst_rd == NO_SLOT)
                begin
                    fst_we = 1'b1; fst_wa = v_idx; fst_wd = SW'(r_slot);
                end
                else
                begin
                    nxt_we = 1'b1; nxt_wa = AW'(lst_rd); nxt_wd = SW'(r_slot);
                end
                lst_we = 1'b1; lst_wa = v_idx; lst_wd = SW'(r_slot);
                edges_next = edges_reg + CNW'(1);
            end
            ucmf_pkg::ST_SINIT:
            begin
                // restore capacities and clear used marks in one sweep
                cap_we  = (ctr_reg < IW'({edges_reg, 1'b0}));
                cap_wa  = AW'(ctr_reg);
                cap_wd  = ~ctr_reg[0];
                used_we = (ctr_reg < IW'(MAX_EDGES));
                used_wa = UAW'(ctr_reg);
                used_wd = 1'b0;
                ctr_next = ctr_reg + IW'(1);
            end
            ucmf_pkg::ST_SCHK:
                ctr_next = '0;
            ucmf_pkg::ST_BCLR:
            begin
                lvl_we = 1'b1; lvl_wa = NW'(ctr_reg); lvl_wd = '0;
                ctr_next = ctr_reg + IW'(1);
            end
            ucmf_pkg::ST_BINIT:
            begin
                lvl_we = 1'b1; lvl_wa = s_idx; lvl_wd = LW'(1);
                que_we = 1'b1; que_wa = '0; que_wd = s_idx;
                head_next = '0;
                tail_next = PW'(1);
            end
            ucmf_pkg::ST_BPOP:
            begin
                que_ra = NW'(head_reg);
                lvl_ra = t_idx;
                if (head_reg != tail_reg) head_next = head_reg + PW'(1);
                ctr_next = '0;
            end
            ucmf_pkg::ST_BX:
            begin
                x_next = que_rd;
                fst_ra = que_rd;
                lvl_ra = que_rd;
            end
            ucmf_pkg::ST_BXL:
            begin
                lvlx_next = lvl_rd;
                e_next    = fst_rd;
            end
            ucmf_pkg::ST_BE:
            begin
                tgt_ra = AW'(e_reg); cap_ra = AW'(e_reg); nxt_ra = AW'(e_reg);
            end
            ucmf_pkg::ST_BY:
            begin
                y_next    = tgt_rd;
                capb_next = cap_rd;
                nx_next   = nxt_rd;
                lvl_ra    = tgt_rd;
            end
            ucmf_pkg::ST_BYL:
            begin
                if ((lvl_rd == '0) && capb_reg)
                begin
                    lvl_we = 1'b1; lvl_wa = y_reg; lvl_wd = lvlx_reg + LW'(1);
                    if (tail_reg < PW'(MAX_NODES))
                    begin
                        que_we = 1'b1; que_wa = NW'(tail_reg); que_wd = y_reg;
                        tail_next = tail_reg + PW'(1);
                    end
                end
                e_next = nx_reg;
            end
            ucmf_pkg::ST_CCP:
            begin
                // cursor copy: read head of list, write it to the cursor ram on the next cycle
                fst_ra = NW'(ctr_reg);
                if (ctr_reg != '0)
                begin
                    cur_we = 1'b1; cur_wa = NW'(ctr_reg - IW'(1)); cur_wd = fst_rd;
                end
                ctr_next = ctr_reg + IW'(1);
                x_next   = s_idx;
                sp_next  = '0;
            end
            ucmf_pkg::ST_DTOP:
            begin
                cur_ra = x_reg;
                lvl_ra = x_reg;
            end
            ucmf_pkg::ST_DC:
            begin
                e_next    = cur_rd;
                lvlx_next = lvl_rd;
                tgt_ra = AW'(cur_rd); cap_ra = AW'(cur_rd); nxt_ra = AW'(cur_rd);
                stk_ra = NW'(sp_reg - PW'(1));
                if ((cur_rd == NO_SLOT) && (sp_reg != '0)) sp_next = sp_reg - PW'(1);
                ctr_next = '0;
            end
            ucmf_pkg::ST_DE:
            begin
                y_next    = tgt_rd;
                capb_next = cap_rd;
                nx_next   = nxt_rd;
                lvl_ra    = tgt_rd;
            end
            ucmf_pkg::ST_DEL:
            begin
                if (advance)
                begin
                    stk_we = 1'b1; stk_wa = NW'(sp_reg); stk_wd = AW'(e_reg);
                    sp_next = sp_reg + PW'(1);
                    x_next  = y_reg;
                end
                else
                begin
                    cur_we = 1'b1; cur_wa = x_reg; cur_wd = nx_reg;
                end
            end
            ucmf_pkg::ST_DP1:
                tgt_ra = stk_rd ^ AW'(1);
            ucmf_pkg::ST_DP2:
            begin
                x_next = tgt_rd;
                cur_ra = tgt_rd;
            end
            ucmf_pkg::ST_DP3:
                nxt_ra = AW'(cur_rd);
            ucmf_pkg::ST_DP4:
            begin
                cur_we = 1'b1; cur_wa = x_reg; cur_wd = nxt_rd;
            end
            ucmf_pkg::ST_DAUG:
            begin
                stk_ra = NW'(sp_reg - PW'(1));
                if (sp_reg == '0)
                begin
                    flow_next = flow_reg + FW'(1);
                    x_next    = s_idx;
                end
                else
                begin
                    sp_next = sp_reg - PW'(1);
                end
            end
            ucmf_pkg::ST_DAUG1:
            begin
                e_next = SW'(stk_rd);
                cap_we = 1'b1; cap_wa = stk_rd; cap_wd = 1'b0;
            end
            ucmf_pkg::ST_DAUG2:
            begin
                cap_we = 1'b1; cap_wa = AW'(e_reg) ^ AW'(1); cap_wd = 1'b1;
            end
            ucmf_pkg::ST_SFIN:
            begin
                left_next = flow_reg;
                walk_next = src_walk;
                done_next = 1'b1;
                fc_next   = 11'(flow_reg);
                pn_next   = '0;
                pe_next   = 1'b0;
                ad_next   = (flow_reg == '0);
            end
            ucmf_pkg::ST_G0:
            begin
                fst_ra  = walk_reg;
                fc_next = '0;
                pn_next = 10'(xp1);
                if (left_reg == '0)
                begin
                    done_next = 1'b1; pn_next = '0; pe_next = 1'b0; ad_next = 1'b1;
                end
                else if (at_sink)
                begin
                    done_next = 1'b1; pe_next = 1'b1;
                    ad_next   = (left_reg == FW'(1));
                    left_next = left_reg - FW'(1);
                    walk_next = src_walk;
                end
            end
            ucmf_pkg::ST_G1:
                e_next = fst_rd;
            ucmf_pkg::ST_G2:
            begin
                tgt_ra  = AW'(e_reg); cap_ra = AW'(e_reg); nxt_ra = AW'(e_reg);
                used_ra = UAW'(e_reg >> 1);
                if (e_reg == NO_SLOT)
                begin
                    // dead end closes the path
                    done_next = 1'b1; pe_next = 1'b1;
                    ad_next   = (left_reg == FW'(1));
                    left_next = left_reg - FW'(1);
                    walk_next = src_walk;
                end
            end
            ucmf_pkg::ST_G3:
            begin
                if (!e_reg[0] && !used_rd && !cap_rd)
                begin
                    used_we = 1'b1; used_wa = UAW'(e_reg >> 1); used_wd = 1'b1;
                    walk_next = tgt_rd;
                    done_next = 1'b1; pe_next = 1'b0; ad_next = 1'b0;
                end
                else
                begin
                    e_next = nxt_rd;
                end
            end
            default:
                ctr_next = ctr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ucmf_pkg::ST_CLR;
            node_count_reg <= 10'd512;
            source_reg     <= 10'd1;
            sink_reg       <= 10'd512;
            mode_reg <= '0;  from_reg <= '0;  to_reg <= '0;
            ctr_reg  <= '0;  edges_reg <= '0;
            x_reg <= '0;  y_reg <= '0;  e_reg <= '0;  nx_reg <= '0;
            capb_reg <= 1'b0;  lvlx_reg <= '0;
            head_reg <= '0;  tail_reg <= '0;  sp_reg <= '0;
            flow_reg <= '0;  left_reg <= '0;  walk_reg <= '0;
            done_reg <= 1'b0;  fc_reg <= '0;  pn_reg <= '0;
            pe_reg <= 1'b0;  ad_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            source_reg     <= source_next;
            sink_reg       <= sink_next;
            mode_reg <= mode_next;  from_reg <= from_next;  to_reg <= to_next;
            ctr_reg  <= ctr_next;   edges_reg <= edges_next;
            x_reg <= x_next;  y_reg <= y_next;  e_reg <= e_next;  nx_reg <= nx_next;
            capb_reg <= capb_next;  lvlx_reg <= lvlx_next;
            head_reg <= head_next;  tail_reg <= tail_next;  sp_reg <= sp_next;
            flow_reg <= flow_next;  left_reg <= left_next;  walk_reg <= walk_next;
            done_reg <= done_next;  fc_reg <= fc_next;  pn_reg <= pn_next;
            pe_reg <= pe_next;  ad_reg <= ad_next;
        end
    end

    assign busy       = (state_reg != ucmf_pkg::ST_IDLE);
    assign done       = done_reg;
    assign flow_count = fc_reg;
    assign path_node  = pn_reg;
    assign path_end   = pe_reg;
    assign all_done   = ad_reg;

    // slot store: target, capacity, next link
    ucmf_ram #(.WIDTH(NW), .DEPTH(2 * MAX_EDGES)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd));
    ucmf_ram #(.WIDTH(1), .DEPTH(2 * MAX_EDGES)) u_cap (
        .clk(clk), .we(cap_we), .waddr(cap_wa), .wdata(cap_wd), .raddr(cap_ra), .rdata(cap_rd));
    ucmf_ram #(.WIDTH(SW), .DEPTH(2 * MAX_EDGES)) u_nxt (
        .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd));
    // node lists
    ucmf_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_fst (
        .clk(clk), .we(fst_we), .waddr(fst_wa), .wdata(fst_wd), .raddr(fst_ra), .rdata(fst_rd));
    ucmf_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_lst (
        .clk(clk), .we(lst_we), .waddr(lst_wa), .wdata(lst_wd), .raddr(lst_ra), .rdata(lst_rd));
    // search state
    ucmf_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_lvl (
        .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_rd));
    ucmf_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_cur (
        .clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));
    ucmf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_que (
        .clk(clk), .we(que_we), .waddr(que_wa), .wdata(que_wd), .raddr(que_ra), .rdata(que_rd));
    ucmf_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));
    // used marks for the path walk
    ucmf_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_used (
        .clk(clk), .we(used_we), .waddr(used_wa), .wdata(used_wd), .raddr(used_ra),
        .rdata(used_rd));

    // result strobe is never high in back-to-back cycles
    `ASSERT_IMP(a_done_pulse, done, !done, "result strobe held two cycles")
    // stack pointer stays within the stack depth and the queue head never passes the tail
    `ASSERT_CLK(a_sp_range, (sp_reg <= PW'(MAX_NODES)), "search stack overrun")
    `ASSERT_CLK(a_queue_order, (head_reg <= tail_reg), "queue head passed tail")

endmodule
